### rtl/pdt_pkg.sv
// Shared widths, codes and the table entry layout for the paired device table.
package pdt_pkg;

    localparam int ACT_W    = 3;
    localparam int TYPE_W   = 8;
    localparam int ADDR_W   = 48;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [ACT_W-1:0] ACT_SAVE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SELECT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

    // register select is address bit 2
    localparam logic REG_TYPE_A = 1'b0;
    localparam logic REG_TYPE_B = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0] dev_type;
        logic [ADDR_W-1:0] dev_addr;
    } entry_t;

endpackage

### rtl/pdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/paired_device_table_single_active_unit.sv
// Saved device table with one active entry: sequencer around a single entry RAM.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      action, device_type, device_addr, entry_index
//  m_        out        m_valid / m_ready      status, found_addr, switch_camera,
//                                              new_camera_type, entry_count
//  APB       in/out     psel, penable, pready  paddr, pwdata, prdata (type_code_a, type_code_b)
//
//  One request at a time; every table read goes through the one registered RAM read port.
//  Query, lookup and select read and check the table entry, or finish at once without a read.
//  A save reads and compares each valid entry, then appends; a duplicate ends the scan, and a
//  rejected one finishes at once. A remove shifts down each entry after the index and reads the
//  new head when it drops the active entry and others remain; a bad index finishes at once.
//  A new request is taken while the previous result still waits on m_; a stalled m_ side
//  holds the finished result and the sequencer in its last step.
//  Reset (aresetn low, synchronous) empties the table, clears the active mark and camera type.
module paired_device_table_single_active_unit #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pdt_pkg::ACT_W-1:0]        s_action,
    input  logic [pdt_pkg::TYPE_W-1:0]       s_device_type,
    input  logic [pdt_pkg::ADDR_W-1:0]       s_device_addr,
    input  logic [pdt_pkg::IDX_W-1:0]        s_entry_index,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pdt_pkg::STATUS_W-1:0]     m_status,
    output logic [pdt_pkg::ADDR_W-1:0]       m_found_addr,
    output logic                             m_switch_camera,
    output logic [pdt_pkg::TYPE_W-1:0]       m_new_camera_type,
    output logic [pdt_pkg::CNT_W-1:0]        m_entry_count,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdt_pkg::APB_AW-1:0]       paddr,
    input  logic [pdt_pkg::APB_DW-1:0]       pwdata,
    output logic [pdt_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    import pdt_pkg::*;

    localparam int              IdxW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAVE_RD,
        S_SAVE_CMP,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [TYPE_W-1:0]     cam_reg;
    logic                  active_valid_reg;
    logic [IdxW-1:0]       active_idx_reg;
    logic                  was_active_reg;
    logic [CNT_W-1:0]      ptr_reg;
    logic [TYPE_W-1:0]     type_a_reg;
    logic [TYPE_W-1:0]     type_b_reg;

    logic [ACT_W-1:0]      req_act_reg;
    logic [TYPE_W-1:0]     req_type_reg;
    logic [ADDR_W-1:0]     req_addr_reg;
    logic [IDX_W-1:0]      req_idx_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ADDR_W-1:0]     found_reg;
    logic                  sw_reg;

    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [ADDR_W-1:0]     m_found_reg;
    logic                  m_sw_reg;
    logic [TYPE_W-1:0]     m_cam_reg;
    logic [CNT_W-1:0]      m_count_reg;

    logic                  rd_en;
    logic [IdxW-1:0]       rd_addr;
    logic                  wr_en;
    logic [IdxW-1:0]       wr_addr;
    entry_t                wr_data;
    entry_t                rd_data;
    logic [CNT_W-1:0]      ptr_plus1;
    logic                  cfg_wr;
    logic                  out_free;
    logic                  s_type_ok;
    logic                  s_idx_active;

    pdt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ptr_plus1    = ptr_reg + CNT_W'(1);
    assign cfg_wr       = psel && penable && pwrite && pready;
    assign out_free     = !m_valid_reg || m_ready;
    assign s_type_ok    = (s_device_type == type_a_reg) || (s_device_type == type_b_reg);
    assign s_idx_active = active_valid_reg && (CNT_W'(active_idx_reg) == s_entry_index);
    assign s_ready      = (state_reg == S_IDLE);
    assign pready       = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_TYPE_A: prdata = APB_DW'(type_a_reg);
            REG_TYPE_B: prdata = APB_DW'(type_b_reg);
            default:    prdata = '0;
        endcase
    end

    // RAM port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    rd_en = 1'b1;
                    if (s_action == ACT_SELECT) begin
                        rd_addr = s_entry_index[IdxW-1:0];
                    end else begin
                        rd_addr = active_idx_reg;
                    end
                end
            end
            S_SAVE_RD: begin
                if (ptr_reg < count_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg[IdxW-1:0];
                end else if (count_reg < DepthCnt) begin
                    wr_en            = 1'b1;
                    wr_addr          = count_reg[IdxW-1:0];
                    wr_data.dev_type = req_type_reg;
                    wr_data.dev_addr = req_addr_reg;
                end
            end
            S_SHIFT_RD: begin
                if (ptr_plus1 < count_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_plus1[IdxW-1:0];
                end else if (was_active_reg && (count_reg != CNT_W'(1))) begin
                    // new head becomes active
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[IdxW-1:0];
                wr_data = rd_data;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            cam_reg          <= '0;
            active_valid_reg <= 1'b0;
            active_idx_reg   <= '0;
            was_active_reg   <= 1'b0;
            ptr_reg          <= '0;
            type_a_reg       <= TYPE_W'(0);
            type_b_reg       <= TYPE_W'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            // a finishing request refills the output slot itself
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                case (paddr[2])
                    REG_TYPE_A: type_a_reg <= pwdata[TYPE_W-1:0];
                    REG_TYPE_B: type_b_reg <= pwdata[TYPE_W-1:0];
                    default:    type_a_reg <= type_a_reg;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_act_reg  <= s_action;
                        req_type_reg <= s_device_type;
                        req_addr_reg <= s_device_addr;
                        req_idx_reg  <= s_entry_index;
                        found_reg    <= '0;
                        sw_reg       <= 1'b0;
                        case (s_action)
                            ACT_SAVE: begin
                                if ((s_device_addr == '0) || !s_type_ok) begin
                                    status_reg <= STS_INVALID;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    status_reg <= STS_OK;
                                    ptr_reg    <= '0;
                                    state_reg  <= S_SAVE_RD;
                                end
                            end
                            ACT_QUERY, ACT_LOOKUP: begin
                                if (!active_valid_reg) begin
                                    status_reg <= STS_NOT_FOUND;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    status_reg <= STS_OK;
                                    state_reg  <= S_CHECK;
                                end
                            end
                            ACT_SELECT: begin
                                if (s_entry_index >= count_reg) begin
                                    status_reg <= STS_BAD_INDEX;
                                    state_reg  <= S_FINISH;
                                end else if (!s_idx_active) begin
                                    status_reg <= STS_OK;
                                    state_reg  <= S_CHECK;
                                end else begin
                                    status_reg <= STS_OK;
                                    state_reg  <= S_FINISH;
                                end
                            end
                            ACT_REMOVE: begin
                                if (s_entry_index >= count_reg) begin
                                    status_reg <= STS_BAD_INDEX;
                                    state_reg  <= S_FINISH;
                                end else begin
                                    status_reg     <= STS_OK;
                                    was_active_reg <= s_idx_active;
                                    ptr_reg        <= s_entry_index;
                                    state_reg      <= S_SHIFT_RD;
                                end
                            end
                            default: begin
                                status_reg <= STS_INVALID;
                                state_reg  <= S_FINISH;
                            end
                        endcase
                    end
                end

                S_SAVE_RD: begin
                    if (ptr_reg < count_reg) begin
                        state_reg <= S_SAVE_CMP;
                    end else begin
                        if (count_reg < DepthCnt) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            status_reg <= STS_FULL;
                        end
                        state_reg <= S_FINISH;
                    end
                end

                S_SAVE_CMP: begin
                    // duplicate: succeed without change
                    if ((rd_data.dev_type == req_type_reg) &&
                        (rd_data.dev_addr == req_addr_reg)) begin
                        state_reg <= S_FINISH;
                    end else begin
                        ptr_reg   <= ptr_plus1;
                        state_reg <= S_SAVE_RD;
                    end
                end

                S_CHECK: begin
                    state_reg <= S_FINISH;
                    case (req_act_reg)
                        ACT_QUERY: begin
                            if ((rd_data.dev_type == req_type_reg) &&
                                (rd_data.dev_addr == req_addr_reg)) begin
                                status_reg <= STS_OK;
                            end else begin
                                status_reg <= STS_NOT_FOUND;
                            end
                        end
                        ACT_LOOKUP: begin
                            if (rd_data.dev_type == req_type_reg) begin
                                found_reg <= rd_data.dev_addr;
                            end else begin
                                status_reg <= STS_NOT_FOUND;
                            end
                        end
                        ACT_SELECT: begin
                            active_valid_reg <= 1'b1;
                            active_idx_reg   <= req_idx_reg[IdxW-1:0];
                            cam_reg          <= rd_data.dev_type;
                            sw_reg           <= 1'b1;
                        end
                        ACT_REMOVE: begin
                            active_valid_reg <= 1'b1;
                            active_idx_reg   <= '0;
                            if (rd_data.dev_type != cam_reg) begin
                                cam_reg <= rd_data.dev_type;
                                sw_reg  <= 1'b1;
                            end
                        end
                        default: begin
                            status_reg <= STS_INVALID;
                        end
                    endcase
                end

                S_SHIFT_RD: begin
                    if (ptr_plus1 < count_reg) begin
                        state_reg <= S_SHIFT_WR;
                    end else begin
                        count_reg <= count_reg - CNT_W'(1);
                        if (was_active_reg) begin
                            active_valid_reg <= 1'b0;
                            if (count_reg != CNT_W'(1)) begin
                                state_reg <= S_CHECK;
                            end else begin
                                state_reg <= S_FINISH;
                            end
                        end else begin
                            state_reg <= S_FINISH;
                            if (active_valid_reg &&
                                (CNT_W'(active_idx_reg) > req_idx_reg)) begin
                                // active mark moves down with its entry
                                active_idx_reg <= active_idx_reg - IdxW'(1);
                            end
                        end
                    end
                end

                S_SHIFT_WR: begin
                    ptr_reg   <= ptr_plus1;
                    state_reg <= S_SHIFT_RD;
                end

                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_found_reg  <= found_reg;
                        m_sw_reg     <= sw_reg;
                        m_cam_reg    <= cam_reg;
                        m_count_reg  <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_found_addr      = m_found_reg;
    assign m_switch_camera   = m_sw_reg;
    assign m_new_camera_type = m_cam_reg;
    assign m_entry_count     = m_count_reg;

    a_active_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        active_valid_reg |-> (CNT_W'(active_idx_reg) < count_reg))
        else $error("active mark points past the valid entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DepthCnt)
        else $error("entry count exceeds table depth");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (CNT_W'(wr_addr) <= count_reg) &&
                  (count_reg < DepthCnt || state_reg == S_SHIFT_WR))
        else $error("RAM write outside the filled part of the table");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && out_free) |=> m_valid_reg)
        else $error("finished request produced no result");

endmodule
